// ----- sv/rwcs_pkg.sv -----
// Shared types and constants for the wall column setup pipeline.
`timescale 1ns / 1ps
`default_nettype none

package rwcs_pkg;

    localparam logic [1:0] FACE_WEST  = 2'd0;
    localparam logic [1:0] FACE_EAST  = 2'd1;
    localparam logic [1:0] FACE_NORTH = 2'd2;
    localparam logic [1:0] FACE_SOUTH = 2'd3;

    localparam logic [15:0] WALL_SCALE_RESET = 16'd512;

    typedef struct packed {
        logic        hit_side;
        logic [31:0] side_dist_x;
        logic [31:0] side_dist_y;
        logic [31:0] delta_x;
        logic [31:0] delta_y;
        logic        step_x_positive;
        logic        step_y_positive;
        logic [23:0] eye_x;
        logic [23:0] eye_y;
        logic signed [19:0] dir_x;
        logic signed [19:0] dir_y;
    } rwcs_req_t;

    typedef struct packed {
        logic [31:0] wall_distance;
        logic [1:0]  wall_face;
        logic [15:0] column_height;
        logic [8:0]  first_row;
        logic [8:0]  last_row;
        logic [5:0]  texel_column;
        logic [31:0] texel_step;
        logic [31:0] texel_row_start;
    } rwcs_rsp_t;

    typedef struct packed {
        logic [31:0] wall_dist;
        logic [1:0]  face;
        logic [5:0]  col;
        logic        hsat;
    } rwcs_front_t;

    typedef struct packed {
        logic [31:0] wall_dist;
        logic [1:0]  face;
        logic [5:0]  col;
        logic [15:0] h;
        logic [8:0]  first;
        logic [8:0]  last;
        logic [14:0] offs;
    } rwcs_mid_t;

endpackage

`default_nettype wire

// ----- sv/rwcs_front.sv -----
// Front stages: wall distance, face, height saturation flag and texture column.
`timescale 1ns / 1ps
`default_nettype none

module rwcs_front #(
    parameter int TEX_COLS = 64
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 in_valid,
    input  wire rwcs_pkg::rwcs_req_t  req,
    input  wire logic [15:0]          wall_scale,
    output logic                      out_valid,
    output rwcs_pkg::rwcs_front_t     out_data
);
    import rwcs_pkg::*;

    localparam int CP_W = 32 + $clog2(TEX_COLS + 1);

    logic        s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic [31:0] s1_dist_reg;
    logic [1:0]  s1_face_reg;
    logic        s1_hsat_reg, s1_neg_reg, s1_mirror_reg;
    logic [19:0] s1_mag_reg;
    logic [23:0] s1_eye_reg;
    logic [31:0] s2_dist_reg, s2_prod_reg;
    logic [1:0]  s2_face_reg;
    logic        s2_hsat_reg, s2_neg_reg, s2_mirror_reg;
    logic [23:0] s2_eye_reg;
    logic [31:0] s3_dist_reg, s3_frac_reg;
    logic [1:0]  s3_face_reg;
    logic        s3_hsat_reg, s3_mirror_reg;
    rwcs_front_t s4_reg;

    logic [31:0] s1_dist_next;
    logic [1:0]  s1_face_next;
    logic        s1_neg_next, s1_mirror_next;
    logic [19:0] s1_raw, s1_mag_next;
    logic [23:0] s1_eye_next;
    logic [51:0] s2_full;
    logic [31:0] s3_frac_next;
    logic [CP_W-1:0] s4_full;
    logic [15:0] s4_col, s4_col_next;

    always_comb
    begin
        if (req.hit_side == 1'b0)
        begin
            s1_dist_next = (req.side_dist_x >= req.delta_x) ?
                           req.side_dist_x - req.delta_x : 32'd0;
            s1_face_next = req.step_x_positive ? FACE_WEST : FACE_EAST;
            s1_eye_next  = req.eye_y;
            s1_raw       = req.dir_y;
        end
        else
        begin
            s1_dist_next = (req.side_dist_y >= req.delta_y) ?
                           req.side_dist_y - req.delta_y : 32'd0;
            s1_face_next = req.step_y_positive ? FACE_NORTH : FACE_SOUTH;
            s1_eye_next  = req.eye_x;
            s1_raw       = req.dir_x;
        end
        s1_neg_next    = s1_raw[19];
        s1_mag_next    = s1_neg_next ? 20'(-s1_raw) : s1_raw;
        s1_mirror_next = req.hit_side ? req.dir_y[19] : (req.dir_x > 20'sd0);
    end

    assign s2_full      = s1_dist_reg * s1_mag_reg;
    assign s3_frac_next = {s2_eye_reg[15:0], 16'd0} +
                          (s2_neg_reg ? 32'(-s2_prod_reg) : s2_prod_reg);
    assign s4_full      = CP_W'(s3_frac_reg) * CP_W'(TEX_COLS);
    assign s4_col       = 16'(s4_full >> 32);
    assign s4_col_next  = s3_mirror_reg ? 16'(TEX_COLS - 1) - s4_col : s4_col;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_dist_reg   <= s1_dist_next;
            s1_face_reg   <= s1_face_next;
            s1_hsat_reg   <= {16'd0, wall_scale} >= s1_dist_next;
            s1_neg_reg    <= s1_neg_next;
            s1_mirror_reg <= s1_mirror_next;
            s1_mag_reg    <= s1_mag_next;
            s1_eye_reg    <= s1_eye_next;

            s2_dist_reg   <= s1_dist_reg;
            s2_prod_reg   <= s2_full[31:0];
            s2_face_reg   <= s1_face_reg;
            s2_hsat_reg   <= s1_hsat_reg;
            s2_neg_reg    <= s1_neg_reg;
            s2_mirror_reg <= s1_mirror_reg;
            s2_eye_reg    <= s1_eye_reg;

            s3_dist_reg   <= s2_dist_reg;
            s3_frac_reg   <= s3_frac_next;
            s3_face_reg   <= s2_face_reg;
            s3_hsat_reg   <= s2_hsat_reg;
            s3_mirror_reg <= s2_mirror_reg;

            s4_reg.wall_dist <= s3_dist_reg;
            s4_reg.face      <= s3_face_reg;
            s4_reg.col       <= s4_col_next[5:0];
            s4_reg.hsat      <= s3_hsat_reg;
        end
    end

    assign out_valid = s4_valid_reg;
    assign out_data  = s4_reg;

endmodule

`default_nettype wire

// ----- sv/rwcs_div_pipe.sv -----
// Pipelined restoring divider, one quotient bit per stage, with sideband data.
`timescale 1ns / 1ps
`default_nettype none

module rwcs_div_pipe #(
    parameter int DEN_W  = 32,
    parameter int Q_W    = 16,
    parameter int SIDE_W = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [DEN_W-1:0]  rem_init,
    input  wire logic [Q_W-1:0]    num,
    input  wire logic [DEN_W-1:0]  den,
    input  wire logic [SIDE_W-1:0] side_in,
    output logic                   out_valid,
    output logic [Q_W-1:0]         quo,
    output logic [SIDE_W-1:0]      side_out
);

    logic              vld_reg  [Q_W];
    logic [DEN_W-1:0]  rem_reg  [Q_W];
    logic [DEN_W-1:0]  den_reg  [Q_W];
    logic [Q_W-1:0]    num_reg  [Q_W];
    logic [Q_W-1:0]    quo_reg  [Q_W];
    logic [SIDE_W-1:0] side_reg [Q_W];

    for (genvar k = 0; k < Q_W; k++)
    begin : g_stage
        logic              vld_prev;
        logic [DEN_W-1:0]  rem_prev, den_prev;
        logic [Q_W-1:0]    num_prev, quo_prev, quo_next;
        logic [SIDE_W-1:0] side_prev;
        logic [DEN_W:0]    shifted, diff;
        logic              ge;

        if (k == 0)
        begin : g_first
            assign vld_prev  = in_valid;
            assign rem_prev  = rem_init;
            assign den_prev  = den;
            assign num_prev  = num;
            assign quo_prev  = '0;
            assign side_prev = side_in;
        end
        else
        begin : g_rest
            assign vld_prev  = vld_reg[k-1];
            assign rem_prev  = rem_reg[k-1];
            assign den_prev  = den_reg[k-1];
            assign num_prev  = num_reg[k-1];
            assign quo_prev  = quo_reg[k-1];
            assign side_prev = side_reg[k-1];
        end

        assign shifted = {rem_prev, num_prev[Q_W-1-k]};
        assign diff    = shifted - {1'b0, den_prev};
        assign ge      = shifted >= {1'b0, den_prev};

        always_comb
        begin
            quo_next            = quo_prev;
            quo_next[Q_W-1-k]   = ge;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
                den_reg[k]  <= den_prev;
                num_reg[k]  <= num_prev;
                quo_reg[k]  <= quo_next;
                side_reg[k] <= side_prev;
            end
        end
    end

    assign out_valid = vld_reg[Q_W-1];
    assign quo       = quo_reg[Q_W-1];
    assign side_out  = side_reg[Q_W-1];

endmodule

`default_nettype wire

// ----- sv/rwcs_back.sv -----
// Back stages: texture step saturation, start row product and result register.
`timescale 1ns / 1ps
`default_nettype none

module rwcs_back #(
    parameter int Q_W = 23
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  wire logic [Q_W-1:0]     quo,
    input  wire rwcs_pkg::rwcs_mid_t mid,
    output logic                    out_valid,
    output rwcs_pkg::rwcs_rsp_t     rsp
);
    import rwcs_pkg::*;

    logic        b1_valid_reg, b2_valid_reg, b3_valid_reg;
    rwcs_mid_t   b1_mid_reg, b2_mid_reg;
    logic [31:0] b1_step_reg, b2_step_reg;
    logic [46:0] b2_prod_reg;
    rwcs_rsp_t   b3_reg;
    logic [31:0] b1_step_next;
    logic [46:0] b2_prod_next;

    assign b1_step_next = (mid.h == 16'd0) ? 32'hFFFF_FFFF : 32'(quo);
    assign b2_prod_next = b1_mid_reg.offs * b1_step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
            b3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            b1_valid_reg <= in_valid;
            b2_valid_reg <= b1_valid_reg;
            b3_valid_reg <= b2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b1_mid_reg  <= mid;
            b1_step_reg <= b1_step_next;
            b2_mid_reg  <= b1_mid_reg;
            b2_step_reg <= b1_step_reg;
            b2_prod_reg <= b2_prod_next;

            b3_reg.wall_distance   <= b2_mid_reg.wall_dist;
            b3_reg.wall_face       <= b2_mid_reg.face;
            b3_reg.column_height   <= b2_mid_reg.h;
            b3_reg.first_row       <= b2_mid_reg.first;
            b3_reg.last_row        <= b2_mid_reg.last;
            b3_reg.texel_column    <= b2_mid_reg.col;
            b3_reg.texel_step      <= b2_step_reg;
            b3_reg.texel_row_start <= (b2_prod_reg[46:32] != 15'd0) ?
                                      32'hFFFF_FFFF : b2_prod_reg[31:0];
        end
    end

    assign out_valid = b3_valid_reg;
    assign rsp       = b3_reg;

endmodule

`default_nettype wire

// ----- sv/raycast_wall_column_setup.sv -----
// Top level of the wall column setup pipeline.
// Usage:
//   One request per screen column carries the final grid-walk state of a ray
//   (req, req_valid, req_stall). One response per request (rsp, rsp_valid,
//   rsp_stall) gives wall distance, face, height, drawn rows, texture column,
//   texture step and starting texture row.
//   wall_scale is written through cfg_we/cfg_data; the user must do so only while the
//   pipeline is empty, which the block itself does not enforce. Stages:
//   4 front stages, 16 stages of the height divider (one quotient bit each),
//   1 row stage, one stage per bit of the texture step divider, 3 back stages.
// Throughput: one request per cycle unless stalled, set by the one-bit-per-stage dividers.
// Reset: all stage valids clear, wall_scale returns to 512.
// Stall: while a response waits under rsp_stall, every stage holds and
//   req_stall is high; empty stages still fill while the output is empty.
`timescale 1ns / 1ps
`default_nettype none

module raycast_wall_column_setup #(
    parameter int SCREEN_ROWS = 512,
    parameter int TEX_COLS    = 64,
    parameter int TEX_ROWS    = 64
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [15:0]         cfg_data,
    input  wire logic                req_valid,
    output logic                     req_stall,
    input  wire rwcs_pkg::rwcs_req_t req,
    output logic                     rsp_valid,
    input  wire logic                rsp_stall,
    output rwcs_pkg::rwcs_rsp_t      rsp
);
    import rwcs_pkg::*;

    localparam int HALF   = SCREEN_ROWS / 2;
    localparam int Q2_W   = $clog2(TEX_ROWS * 65536 + 1);
    localparam int F_W    = $bits(rwcs_front_t);
    localparam int M_W    = $bits(rwcs_mid_t);

    logic        en;
    logic [15:0] wall_scale_reg;

    logic        front_valid;
    rwcs_front_t front_data;
    logic        d1_valid;
    logic [15:0] d1_quo;
    logic [F_W-1:0] d1_side;
    rwcs_front_t d1_front;

    logic        row_valid_reg;
    rwcs_mid_t   row_reg;
    rwcs_mid_t   row_next;
    logic [16:0] hh, end_sum, start_v, last_v;

    logic        d2_valid;
    logic [Q2_W-1:0] d2_quo;
    logic [M_W-1:0]  d2_side;

    assign en        = !(rsp_valid && rsp_stall);
    assign req_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wall_scale_reg <= WALL_SCALE_RESET;
        end
        else if (cfg_we)
        begin
            wall_scale_reg <= cfg_data;
        end
    end

    rwcs_front #(
        .TEX_COLS (TEX_COLS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (req_valid),
        .req        (req),
        .wall_scale (wall_scale_reg),
        .out_valid  (front_valid),
        .out_data   (front_data)
    );

    rwcs_div_pipe #(
        .DEN_W  (32),
        .Q_W    (16),
        .SIDE_W (F_W)
    ) u_height_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (front_valid),
        .rem_init  ({16'd0, wall_scale_reg}),
        .num       (16'd0),
        .den       (front_data.wall_dist),
        .side_in   (front_data),
        .out_valid (d1_valid),
        .quo       (d1_quo),
        .side_out  (d1_side)
    );

    assign d1_front = rwcs_front_t'(d1_side);

    always_comb
    begin
        row_next.wall_dist = d1_front.wall_dist;
        row_next.face      = d1_front.face;
        row_next.col       = d1_front.col;
        row_next.h         = d1_front.hsat ? 16'hFFFF : d1_quo;
        hh                 = 17'(row_next.h >> 1);
        end_sum            = hh + 17'(HALF);
        start_v            = (hh >= 17'(HALF)) ? 17'd0 : 17'(HALF) - hh;
        last_v             = (end_sum >= 17'(SCREEN_ROWS)) ?
                             17'(SCREEN_ROWS - 1) : end_sum;
        row_next.first     = start_v[8:0];
        row_next.last      = last_v[8:0];
        row_next.offs      = (hh > 17'(HALF)) ? 15'(hh - 17'(HALF)) : 15'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            row_valid_reg <= d1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            row_reg <= row_next;
        end
    end

    rwcs_div_pipe #(
        .DEN_W  (16),
        .Q_W    (Q2_W),
        .SIDE_W (M_W)
    ) u_step_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (row_valid_reg),
        .rem_init  (16'd0),
        .num       (Q2_W'(TEX_ROWS) << 16),
        .den       (row_reg.h),
        .side_in   (row_reg),
        .out_valid (d2_valid),
        .quo       (d2_quo),
        .side_out  (d2_side)
    );

    rwcs_back #(
        .Q_W (Q2_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (d2_valid),
        .quo       (d2_quo),
        .mid       (rwcs_mid_t'(d2_side)),
        .out_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

// ----- sv/rwcs_check.sv -----
// Port checker for the wall column setup pipeline and its bind.
`timescale 1ns / 1ps
`default_nettype none

module rwcs_check (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                req_stall,
    input wire logic                rsp_valid,
    input wire logic                rsp_stall,
    input wire rwcs_pkg::rwcs_rsp_t rsp
);

    a_reset_empty: assert property (@(posedge clk) !rst_n |-> !rsp_valid)
        else $error("response valid during reset");

    a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall == (rsp_valid && rsp_stall))
        else $error("request stall does not follow response stall");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled response changed");

    a_zero_dist: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.wall_distance == 32'd0 |-> rsp.column_height == 16'hFFFF)
        else $error("zero distance did not saturate height");

    a_zero_height: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.column_height == 16'd0 |->
        rsp.texel_step == 32'hFFFF_FFFF && rsp.texel_row_start == 32'd0)
        else $error("zero height did not saturate texture step");

endmodule

bind raycast_wall_column_setup rwcs_check u_rwcs_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

`default_nettype wire
